[design/mm4_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// mm4_pkg
// Types and constants shared by the 4x4 fixed-point matrix product engine.
// ----------------------------------------------------------------------------
package mm4_pkg;

	localparam int FRAC_BITS = 16;
	localparam int ELEM_W    = 32;
	localparam int ROW_W     = 2;
	localparam int DIM       = 4;
	localparam int STORE_N   = DIM * DIM;
	localparam int IDX_W     = 4;
	localparam int PROD_W    = 2 * ELEM_W;
	localparam int PAIR_W    = PROD_W + 1;
	localparam int SUM_W     = PROD_W + 2;

	localparam logic [ELEM_W-1:0] SAT_MAX = {1'b0, {(ELEM_W-1){1'b1}}};
	localparam logic [ELEM_W-1:0] SAT_MIN = {1'b1, {(ELEM_W-1){1'b0}}};

	typedef logic signed [ELEM_W-1:0] elem_t;
	typedef logic signed [PROD_W-1:0] prod_t;

	typedef enum logic {
		CMD_LOAD = 1'b0,
		CMD_MULT = 1'b1
	} cmd_t;

	typedef struct packed {
		cmd_t             command;
		logic [ROW_W-1:0] row_index;
		elem_t            elem0;
		elem_t            elem1;
		elem_t            elem2;
		elem_t            elem3;
	} req_t;

	typedef struct packed {
		logic [ROW_W-1:0] out_row;
		elem_t            prod0;
		elem_t            prod1;
		elem_t            prod2;
		elem_t            prod3;
		logic             saturated;
	} rsp_t;

	// Load strobes for the adder and output stages of each column unit.
	typedef struct packed {
		logic ld_s3;
		logic ld_s4;
		logic ld_s5;
	} pipe_ctl_t;

endpackage
`default_nettype wire

[design/mm4_if.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// mm4 channel interfaces
// Valid/ready channels carrying requests into and result rows out of the engine.
// ----------------------------------------------------------------------------
interface mm4_req_if;
	logic          valid;
	logic          ready;
	mm4_pkg::req_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface mm4_rsp_if;
	logic          valid;
	logic          ready;
	mm4_pkg::rsp_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

[design/matrix_multiply_4x4_core.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// matrix_multiply_4x4_core
// Streaming 4x4 matrix product in signed Q16.16 with a loadable right matrix.
// ----------------------------------------------------------------------------
// A load request writes one row of the right-hand matrix into a 16-entry store
// that reset clears to zero; it gives no result. A multiply request carries one
// row of the left matrix. Its result row moves to the result port through the
// input, product, adder and output registers, and is held there until taken.
// Each column is the exact sum of four products, shifted right by the fraction
// bits and saturated, with a flag when any column clipped. The engine takes one
// request per cycle through five register stages: input, sixteen parallel
// multipliers, two adder stages and the saturation/output stage. A load takes
// effect as it leaves the input stage, so requests act in the order they were
// accepted. Backpressure on the result side stalls the pipe back to its first empty stage.
// ----------------------------------------------------------------------------
module matrix_multiply_4x4_core (
	input  logic      clk,
	input  logic      arst_n,
	mm4_req_if.sink   req,
	mm4_rsp_if.source rsp
);
	import mm4_pkg::*;

	logic en_s1, en_s2, en_s3, en_s4, en_s5;
	logic v_s1, v_s2, v_s3, v_s4, v_s5;

	req_t             d_s1;
	logic [ROW_W-1:0] row_s2, row_s3, row_s4, row_s5;
	elem_t            rmat_q [STORE_N];
	elem_t            lrow   [DIM];
	prod_t            prod_s2 [DIM][DIM];
	elem_t            res_s5 [DIM];
	logic [DIM-1:0]   clip_s5;
	pipe_ctl_t        ctl;

	assign en_s5     = !v_s5 || rsp.ready;
	assign en_s4     = !v_s4 || en_s5;
	assign en_s3     = !v_s3 || en_s4;
	assign en_s2     = !v_s2 || en_s3;
	assign en_s1     = !v_s1 || en_s2;
	assign req.ready = en_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (en_s1) v_s1 <= req.valid;
			if (en_s2) v_s2 <= v_s1 && (d_s1.command == CMD_MULT);
			if (en_s3) v_s3 <= v_s2;
			if (en_s4) v_s4 <= v_s3;
			if (en_s5) v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1 && req.valid) begin
			d_s1 <= req.data;
		end
	end

	// Right-matrix store, entry 4*k+j holds R[k][j].
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < STORE_N; i++) begin
				rmat_q[i] <= '0;
			end
		end else if (en_s2 && v_s1 && (d_s1.command == CMD_LOAD)) begin
			rmat_q[{d_s1.row_index, 2'd0}] <= d_s1.elem0;
			rmat_q[{d_s1.row_index, 2'd1}] <= d_s1.elem1;
			rmat_q[{d_s1.row_index, 2'd2}] <= d_s1.elem2;
			rmat_q[{d_s1.row_index, 2'd3}] <= d_s1.elem3;
		end
	end

	always_comb begin
		lrow[0] = d_s1.elem0;
		lrow[1] = d_s1.elem1;
		lrow[2] = d_s1.elem2;
		lrow[3] = d_s1.elem3;
	end

	always_ff @(posedge clk) begin
		if (en_s2 && v_s1 && (d_s1.command == CMD_MULT)) begin
			row_s2 <= d_s1.row_index;
			for (int k = 0; k < DIM; k++) begin
				for (int c = 0; c < DIM; c++) begin
					prod_s2[k][c] <= PROD_W'(lrow[k]) * PROD_W'(rmat_q[IDX_W'(k * DIM + c)]);
				end
			end
		end
	end

	assign ctl.ld_s3 = en_s3 && v_s2;
	assign ctl.ld_s4 = en_s4 && v_s3;
	assign ctl.ld_s5 = en_s5 && v_s4;

	always_ff @(posedge clk) begin
		if (ctl.ld_s3) row_s3 <= row_s2;
		if (ctl.ld_s4) row_s4 <= row_s3;
		if (ctl.ld_s5) row_s5 <= row_s4;
	end

	for (genvar c = 0; c < DIM; c++) begin : g_col
		mm4_dot u_dot (
			.clk     (clk),
			.ctl     (ctl),
			.p0      (prod_s2[0][c]),
			.p1      (prod_s2[1][c]),
			.p2      (prod_s2[2][c]),
			.p3      (prod_s2[3][c]),
			.res_s5  (res_s5[c]),
			.clip_s5 (clip_s5[c])
		);
	end

	assign rsp.valid          = v_s5;
	assign rsp.data.out_row   = row_s5;
	assign rsp.data.prod0     = res_s5[0];
	assign rsp.data.prod1     = res_s5[1];
	assign rsp.data.prod2     = res_s5[2];
	assign rsp.data.prod3     = res_s5[3];
	assign rsp.data.saturated = |clip_s5;

endmodule
`default_nettype wire

[design/mm4_dot.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// mm4_dot
// Sums four full products of one result column in two adder stages, then
// shifts out the fraction bits and saturates to the element width.
// ----------------------------------------------------------------------------
module mm4_dot (
	input  logic                  clk,
	input  mm4_pkg::pipe_ctl_t    ctl,
	input  mm4_pkg::prod_t        p0,
	input  mm4_pkg::prod_t        p1,
	input  mm4_pkg::prod_t        p2,
	input  mm4_pkg::prod_t        p3,
	output mm4_pkg::elem_t        res_s5,
	output logic                  clip_s5
);
	import mm4_pkg::*;

	logic signed [PAIR_W-1:0] pair0_s3;
	logic signed [PAIR_W-1:0] pair1_s3;
	logic signed [SUM_W-1:0]  sum_s4;
	logic signed [SUM_W-1:0]  shifted;
	logic                     fits;

	always_ff @(posedge clk) begin
		if (ctl.ld_s3) begin
			pair0_s3 <= PAIR_W'(p0) + PAIR_W'(p1);
			pair1_s3 <= PAIR_W'(p2) + PAIR_W'(p3);
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.ld_s4) begin
			sum_s4 <= SUM_W'(pair0_s3) + SUM_W'(pair1_s3);
		end
	end

	// The shifted sum fits when every bit above the element's sign bit matches it.
	always_comb begin
		shifted = sum_s4 >>> FRAC_BITS;
		fits    = (&shifted[SUM_W-1:ELEM_W-1]) || !(|shifted[SUM_W-1:ELEM_W-1]);
	end

	always_ff @(posedge clk) begin
		if (ctl.ld_s5) begin
			clip_s5 <= !fits;
			if (fits) begin
				res_s5 <= shifted[ELEM_W-1:0];
			end else if (sum_s4[SUM_W-1]) begin
				res_s5 <= SAT_MIN;
			end else begin
				res_s5 <= SAT_MAX;
			end
		end
	end

endmodule
`default_nettype wire

[design/mm4_checker.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// mm4_checker
// Port-level checks on the matrix product engine, bound to its top level.
// ----------------------------------------------------------------------------
module mm4_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          in_valid,
	input logic          in_ready,
	input mm4_pkg::cmd_t in_command,
	input logic          out_valid,
	input logic          out_ready,
	input mm4_pkg::rsp_t out_data
);
	import mm4_pkg::*;

	logic mult_acc;
	assign mult_acc = in_valid && in_ready && (in_command == CMD_MULT);

	// A result that is not taken stays on the port unchanged.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result changed or vanished while stalled");

	// The input side only stalls when the full pipe is held by the result side.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid && !out_ready)
		else $error("input stalled without result backpressure");

	// With the result side ready while it passes through, an accepted multiply request reaches the result port.
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		$past(mult_acc, 5) && $past(arst_n, 1) && $past(arst_n, 2) && $past(arst_n, 3)
		&& $past(arst_n, 4) && $past(arst_n, 5) && $past(out_ready, 1)
		&& $past(out_ready, 2) && $past(out_ready, 3) && $past(out_ready, 4)
		|-> out_valid)
		else $error("multiply result missing after pipeline latency");

endmodule

bind matrix_multiply_4x4_core mm4_checker u_mm4_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (req.valid),
	.in_ready   (req.ready),
	.in_command (req.data.command),
	.out_valid  (rsp.valid),
	.out_ready  (rsp.ready),
	.out_data   (rsp.data)
);
`default_nettype wire
